### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the rtl; define ASSERT_OFF to compile them out
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: reset-qualified check");
// checked at every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed: unconditional check");
`else
`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/pwl_pkg.sv
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and constants of the piecewise linear evaluator
// ----------------------------------------------------------------------------
package pwl_pkg;

  // default sizing
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int RESULT_DEPTH    = 2;

  // field widths
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 2;

  typedef enum logic {
    CMD_EVAL = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_DOMAIN     = 2'd1,
    STAT_BAD_LOAD   = 2'd2,
    STAT_INCOMPLETE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOMAIN_MIN  = 2'd0,
    REG_DOMAIN_MAX  = 2'd1,
    REG_FIRST_IMAGE = 2'd2,
    REG_POINT_COUNT = 2'd3
  } cfg_reg_e;

  // one input item
  typedef struct packed {
    cmd_e                     cmd;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] rate;
  } item_t;

  // one result item
  typedef struct packed {
    logic signed [DATA_W-1:0] image;
    logic signed [DATA_W-1:0] slope;
    logic [IDX_W-1:0]         segment;
    status_e                  status;
  } result_t;

  // configuration as seen by front and back
  typedef struct packed {
    logic signed [DATA_W-1:0] domain_min;
    logic signed [DATA_W-1:0] domain_max;
    logic signed [DATA_W-1:0] first_image;
    logic [CNT_W-1:0]         eff_count;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    cmd_e                     cmd;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] rate;
    logic                     out_of_domain;
    logic                     index_in_range;
  } task_t;

endpackage

### rtl/pwl_fifo.sv
// ----------------------------------------------------------------------------
// pwl_fifo
// Small register queue used between front and back and on the result side
// ----------------------------------------------------------------------------
module pwl_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/pwl_front.sv
// ----------------------------------------------------------------------------
// pwl_front
// Accepts input items, checks domain and index range, queues them for the back
// ----------------------------------------------------------------------------
module pwl_front import pwl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  full_o,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  input  logic  q_pop_i,
  output logic  q_empty_o,
  output task_t q_head_o
);

  task_t task_w;

  // classify the incoming item
  always_comb begin
    task_w.cmd            = item_i.cmd;
    task_w.entry_index    = item_i.entry_index;
    task_w.position       = item_i.position;
    task_w.rate           = item_i.rate;
    task_w.out_of_domain  = ($signed(item_i.position) < $signed(cfg_i.domain_min)) ||
                            ($signed(item_i.position) > $signed(cfg_i.domain_max));
    task_w.index_in_range = (CNT_W'(item_i.entry_index) < cfg_i.eff_count);
  end

  // task queue toward the back
  pwl_fifo #(
    .T     (task_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_task_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (task_w),
    .full_o  (full_o),
    .pop_i   (q_pop_i),
    .empty_o (q_empty_o),
    .data_o  (q_head_o)
  );

endmodule

### rtl/pwl_back.sv
// ----------------------------------------------------------------------------
// pwl_back
// Breakpoint table, binary search sequencer and line multiply-add
// ----------------------------------------------------------------------------
module pwl_back import pwl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    q_empty_i,
  input  task_t   q_head_i,
  output logic    q_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  localparam int ADDR_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LOG_DEPTH  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 0;
  localparam int SRCH_STEPS = (LOG_DEPTH > IDX_W) ? IDX_W : LOG_DEPTH;
  localparam int BIT_W      = $clog2(IDX_W);
  localparam int DX_W       = DATA_W + 1;
  localparam int LO_W       = 17;
  localparam int HI_W       = DX_W - LO_W;
  localparam int PLO_W      = DATA_W + LO_W + 1;
  localparam int PHI_W      = DATA_W + HI_W;
  localparam int PROD_W     = DATA_W + DX_W;
  localparam int CLAMP_W    = 42;
  localparam int SUM_W      = CLAMP_W + 1;

  localparam logic signed [PROD_W-1:0] CLAMP_POS = 65'sd1099511627776;
  localparam logic signed [PROD_W-1:0] CLAMP_NEG = -CLAMP_POS;
  localparam logic signed [SUM_W-1:0]  SAT_MAX   = 43'sd2147483647;
  localparam logic signed [SUM_W-1:0]  SAT_MIN   = -43'sd2147483648;

  localparam result_t BAD_LOAD_RES = '{image: '0, slope: '0, segment: '0,
                                       status: STAT_BAD_LOAD};

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SRCH_RD  = 9'b000000010,
    S_SRCH_CMP = 9'b000000100,
    S_FETCH    = 9'b000001000,
    S_LINE     = 9'b000010000,
    S_MUL      = 9'b000100000,
    S_SUM      = 9'b001000000,
    S_ADD      = 9'b010000000,
    S_RESP     = 9'b100000000
  } bstate_e;

  bstate_e                  state_q, state_d;
  logic [CNT_W-1:0]         entries_q, entries_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [BIT_W-1:0]         bit_q, bit_d;
  logic [IDX_W-1:0]         cand_q, cand_d;
  logic                     cand_ok_q, cand_ok_d;
  logic                     wr_en_q, wr_en_d;

  // payload registers
  task_t                    itm_q;
  result_t                  res_q;
  logic signed [DX_W-1:0]   dx_q;
  logic signed [DATA_W-1:0] mul_slope_q;
  logic signed [DATA_W-1:0] base_q;
  logic signed [PLO_W-1:0]  pp_lo_q;
  logic signed [PHI_W-1:0]  pp_hi_q;
  logic signed [CLAMP_W-1:0] clamp_q;

  // breakpoint table and its registered read data
  logic signed [DATA_W-1:0] pos_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] slp_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] img_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_pos_q, rd_slp_q, rd_img_q;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     mem_we;

  // decode of queue head and current item
  logic                     head_load, head_k_zero, load_ok, table_short;
  logic                     itm_load, x_below, x_above;
  logic [IDX_W-1:0]         cand_w;
  logic                     cand_ok_w;
  logic signed [DX_W-1:0]   dx_w;
  logic signed [PLO_W-1:0]  pp_lo_w;
  logic signed [PHI_W-1:0]  pp_hi_w;
  logic signed [PROD_W-1:0] prod_w, shifted_w;
  logic signed [CLAMP_W-1:0] clamp_w;
  logic signed [SUM_W-1:0]  sum_w;
  logic signed [DATA_W-1:0] sat_w;
  result_t                  idle_res, add_res;

  assign head_load   = (q_head_i.cmd == CMD_LOAD);
  assign head_k_zero = (q_head_i.entry_index == '0);
  assign load_ok     = q_head_i.index_in_range &&
                       (head_k_zero || (CNT_W'(q_head_i.entry_index) == entries_q));
  assign table_short = (entries_q < cfg_i.eff_count);

  assign itm_load  = (itm_q.cmd == CMD_LOAD);
  assign x_below   = ($signed(itm_q.position) < $signed(rd_pos_q));
  assign x_above   = ($signed(itm_q.position) > $signed(rd_pos_q));
  assign cand_w    = idx_q | (IDX_W'(1) << bit_q);
  assign cand_ok_w = (CNT_W'(cand_w) < cfg_i.eff_count);

  // offset from the breakpoint
  assign dx_w = $signed({itm_q.position[DATA_W-1], itm_q.position}) -
                $signed({rd_pos_q[DATA_W-1], rd_pos_q});

  // slope times offset as two partial products
  assign pp_lo_w = mul_slope_q * $signed({1'b0, dx_q[LO_W-1:0]});
  assign pp_hi_w = mul_slope_q * $signed(dx_q[DX_W-1:LO_W]);

  // recombine, floor shift and clamp
  always_comb begin
    prod_w    = (PROD_W'(pp_hi_q) <<< LO_W) + PROD_W'(pp_lo_q);
    shifted_w = prod_w >>> FRAC_BITS;
    if (shifted_w > CLAMP_POS) begin
      clamp_w = CLAMP_POS[CLAMP_W-1:0];
    end else if (shifted_w < CLAMP_NEG) begin
      clamp_w = CLAMP_NEG[CLAMP_W-1:0];
    end else begin
      clamp_w = shifted_w[CLAMP_W-1:0];
    end
  end

  // add base image and saturate
  always_comb begin
    sum_w = SUM_W'(base_q) + SUM_W'(clamp_q);
    if (sum_w > SAT_MAX) begin
      sat_w = SAT_MAX[DATA_W-1:0];
    end else if (sum_w < SAT_MIN) begin
      sat_w = SAT_MIN[DATA_W-1:0];
    end else begin
      sat_w = sum_w[DATA_W-1:0];
    end
  end

  // result known straight from the queue head
  always_comb begin
    idle_res = '0;
    if (head_load) begin
      if (!load_ok) begin
        idle_res.status = STAT_BAD_LOAD;
      end else if (head_k_zero) begin
        idle_res.image = cfg_i.first_image;
        idle_res.slope = q_head_i.rate;
      end
    end else if (table_short) begin
      idle_res.status = STAT_INCOMPLETE;
    end else if (q_head_i.out_of_domain) begin
      idle_res.status = STAT_DOMAIN;
    end
  end

  // result of the multiply-add path
  always_comb begin
    add_res.image   = sat_w;
    add_res.slope   = itm_load ? itm_q.rate : mul_slope_q;
    add_res.segment = itm_load ? itm_q.entry_index : idx_q;
    add_res.status  = STAT_OK;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    entries_d  = entries_q;
    idx_d      = idx_q;
    bit_d      = bit_q;
    cand_d     = cand_q;
    cand_ok_d  = cand_ok_q;
    wr_en_d    = wr_en_q;
    q_pop_o    = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          wr_en_d = 1'b0;
          if (head_load) begin
            if (!load_ok) begin
              state_d = S_RESP;
            end else if (head_k_zero) begin
              wr_en_d = 1'b1;
              state_d = S_RESP;
            end else begin
              idx_d   = q_head_i.entry_index - IDX_W'(1);
              state_d = S_FETCH;
            end
          end else if (table_short || q_head_i.out_of_domain) begin
            state_d = S_RESP;
          end else begin
            idx_d = '0;
            if (SRCH_STEPS > 0) begin
              bit_d   = BIT_W'(SRCH_STEPS - 1);
              state_d = S_SRCH_RD;
            end else begin
              state_d = S_FETCH;
            end
          end
        end
      end
      S_SRCH_RD: begin
        cand_d    = cand_w;
        cand_ok_d = cand_ok_w;
        state_d   = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (cand_ok_q && !x_below) begin
          idx_d = cand_q;
        end
        if (bit_q == '0) begin
          state_d = S_FETCH;
        end else begin
          bit_d   = bit_q - BIT_W'(1);
          state_d = S_SRCH_RD;
        end
      end
      S_FETCH: begin
        state_d = S_LINE;
      end
      S_LINE: begin
        if (itm_load && !x_above) begin
          state_d = S_RESP;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        state_d = S_ADD;
      end
      S_ADD: begin
        wr_en_d = itm_load;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (wr_en_q) begin
            entries_d = CNT_W'(itm_q.entry_index) + CNT_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      entries_q <= '0;
      idx_q     <= '0;
      bit_q     <= '0;
      cand_q    <= '0;
      cand_ok_q <= 1'b0;
      wr_en_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      entries_q <= entries_d;
      idx_q     <= idx_d;
      bit_q     <= bit_d;
      cand_q    <= cand_d;
      cand_ok_q <= cand_ok_d;
      wr_en_q   <= wr_en_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          itm_q <= q_head_i;
          res_q <= idle_res;
        end
      end
      S_LINE: begin
        res_q        <= BAD_LOAD_RES;
        dx_q         <= dx_w;
        mul_slope_q  <= rd_slp_q;
        base_q       <= rd_img_q;
      end
      S_MUL: begin
        pp_lo_q <= pp_lo_w;
        pp_hi_q <= pp_hi_w;
      end
      S_SUM: begin
        clamp_q <= clamp_w;
      end
      S_ADD: begin
        res_q <= add_res;
      end
      default: ;
    endcase
  end

  // table access
  assign rd_addr = (state_q == S_SRCH_RD) ? ADDR_W'(cand_w) : ADDR_W'(idx_q);
  assign wr_addr = ADDR_W'(itm_q.entry_index);
  assign mem_we  = (state_q == S_RESP) && !res_full_i && wr_en_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pos_mem[wr_addr] <= itm_q.position;
      slp_mem[wr_addr] <= itm_q.rate;
      img_mem[wr_addr] <= res_q.image;
    end
    rd_pos_q <= pos_mem[rd_addr];
    rd_slp_q <= slp_mem[rd_addr];
    rd_img_q <= img_mem[rd_addr];
  end

  assign res_o = res_q;

endmodule

### rtl/piecewise_linear_evaluator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_evaluator
// Piecewise linear function over a loaded breakpoint table, signed fixed point.
// Each item gives exactly one result, in order. An evaluate runs a binary search
// over the breakpoint memory through its single read port, each probe a read
// state and a compare state, then a fetch, a split multiply, clamp and
// saturating add. A load of a nonzero entry reads the previous breakpoint and
// runs the multiply-add, or is rejected when its position does not rise above
// that breakpoint; entry 0 loads and items rejected by the index, completeness
// or domain checks go straight to the response. A two-entry task queue lets new
// items be taken while the back works, and a two-entry result queue holds
// finished results until popped. The table needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module piecewise_linear_evaluator import pwl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  item_t                item_i,
  output logic                 empty,
  input  logic                 pop,
  output result_t              result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i
);

  localparam int DEPTH_CAP = (TABLE_DEPTH > 31) ? 31 : TABLE_DEPTH;
  localparam logic [CNT_W-1:0] DEPTH_CAP_V = CNT_W'(DEPTH_CAP);

  logic signed [DATA_W-1:0] domain_min_q, domain_max_q, first_image_q;
  logic [CNT_W-1:0]         point_count_q;
  logic [CNT_W-1:0]         eff_count;
  cfg_t                     cfg;

  task_t                    q_head;
  logic                     q_empty, q_pop;
  result_t                  res;
  logic                     res_push, res_full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      domain_min_q  <= 32'sh8000_0000;
      domain_max_q  <= 32'sh7FFF_FFFF;
      first_image_q <= '0;
      point_count_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DOMAIN_MIN:  domain_min_q  <= cfg_wdata_i;
        REG_DOMAIN_MAX:  domain_max_q  <= cfg_wdata_i;
        REG_FIRST_IMAGE: first_image_q <= cfg_wdata_i;
        REG_POINT_COUNT: point_count_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // breakpoint count in use, zero acts as one, capped at the table size and at 31
  always_comb begin
    if (point_count_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (point_count_q > DEPTH_CAP_V) begin
      eff_count = DEPTH_CAP_V;
    end else begin
      eff_count = point_count_q;
    end
  end

  always_comb begin
    cfg.domain_min  = domain_min_q;
    cfg.domain_max  = domain_max_q;
    cfg.first_image = first_image_q;
    cfg.eff_count   = eff_count;
  end

  // intake and classification
  pwl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .item_i    (item_i),
    .cfg_i     (cfg),
    .q_pop_i   (q_pop),
    .q_empty_o (q_empty),
    .q_head_o  (q_head)
  );

  // table, search and arithmetic
  pwl_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  // result queue
  pwl_fifo #(
    .T     (result_t),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (result_o)
  );

  // back never overruns the result queue
  `ASSERT_ALWAYS(a_no_result_overflow, clk_i, !(res_push && res_full))
  // back only takes a task that is there
  `ASSERT_RST(a_no_task_underflow, clk_i, rst_ni, q_pop |-> !q_empty)
  // an accepted item is waiting for the back on the next cycle
  `ASSERT_RST(a_accept_reaches_queue, clk_i, rst_ni, (push && !full) |=> !q_empty)
  // a result transfer always leaves room for the back
  `ASSERT_RST(a_pop_frees_slot, clk_i, rst_ni, (pop && !empty) |=> !res_full)

endmodule
